FILE: hw/rtl/pcba_pkg.sv
// Shared constants, operation codes and types of the point antialiaser.
package pcba_pkg;

  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 160;

  localparam int OP_W    = 2;
  localparam int POS_W   = 17;
  localparam int ADDR_W  = 16;
  localparam int PIX_W   = 8;
  localparam int FRAC_W  = 8;
  localparam int COORD_W = 10;

  localparam int SHADE_DEPTH = 65536;

  localparam logic [POS_W:0] ROUND_BIAS = (POS_W + 1)'(8'h7F);

  localparam logic [OP_W-1:0] OP_WR_PIX   = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_SHADE = 2'd1;
  localparam logic [OP_W-1:0] OP_AA_POINT = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_PIX   = 2'd3;

  typedef struct packed {
    logic onscreen;
    logic at_left;
    logic at_right;
    logic at_top;
    logic at_bot;
  } pcba_pos_t;

endpackage

FILE: hw/rtl/pcba_ram.sv
// Generic single-port synchronous RAM with registered read data.
module pcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/pcba_locate.sv
// Point locator: rounds signed 9.8 coordinates, checks bounds, forms the pixel address.
module pcba_locate #(
  parameter int SCREEN_WIDTH  = pcba_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pcba_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                                   clk,
  input  logic                                                   load,
  input  logic signed [pcba_pkg::POS_W-1:0]                      x_pos,
  input  logic signed [pcba_pkg::POS_W-1:0]                      y_pos,
  input  logic                                                   calc,
  output pcba_pkg::pcba_pos_t                                    pos_r,
  output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0]          base_r
);
  import pcba_pkg::*;

  localparam int FRAME_AW = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam int CMP_W    = COORD_W + 1;

  logic [POS_W-1:0]   x_r;
  logic [POS_W-1:0]   y_r;
  logic [POS_W:0]     sum_x;
  logic [POS_W:0]     sum_y;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic               neg_x;
  logic               neg_y;
  logic               in_x;
  logic               in_y;
  logic [31:0]        base_full;
  pcba_pos_t          pos_nxt;

  // Round with (v + 0x7F) >>> 8; the top bit of the sum is the sign.
  assign sum_x = {x_r[POS_W-1], x_r} + ROUND_BIAS;
  assign sum_y = {y_r[POS_W-1], y_r} + ROUND_BIAS;
  assign neg_x = sum_x[POS_W];
  assign neg_y = sum_y[POS_W];
  assign cx    = COORD_W'(sum_x[POS_W-1:FRAC_W]);
  assign cy    = COORD_W'(sum_y[POS_W-1:FRAC_W]);

  assign in_x = !neg_x && (CMP_W'(cx) < CMP_W'(SCREEN_WIDTH));
  assign in_y = !neg_y && (CMP_W'(cy) < CMP_W'(SCREEN_HEIGHT));

  always_comb begin
    pos_nxt.onscreen = in_x && in_y;
    pos_nxt.at_left  = (cx == '0);
    pos_nxt.at_right = (cx == COORD_W'(SCREEN_WIDTH - 1));
    pos_nxt.at_top   = (cy == '0);
    pos_nxt.at_bot   = (cy == COORD_W'(SCREEN_HEIGHT - 1));
  end

  assign base_full = 32'(cy) * 32'(SCREEN_WIDTH) + 32'(cx);

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x_pos;
      y_r <= y_pos;
    end
    if (calc) begin
      pos_r  <= pos_nxt;
      base_r <= base_full[FRAME_AW-1:0];
    end
  end

endmodule

FILE: hw/rtl/point_cross_blend_antialias.sv
// Top level of the paletted point antialiaser: frame store, shade table, sequencer.
module point_cross_blend_antialias #(
  parameter int SCREEN_WIDTH  = pcba_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pcba_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcba_pkg::OP_W-1:0]         in_op,
  input  logic signed [pcba_pkg::POS_W-1:0] in_x_pos,
  input  logic signed [pcba_pkg::POS_W-1:0] in_y_pos,
  input  logic [pcba_pkg::ADDR_W-1:0]       in_address,
  input  logic [pcba_pkg::PIX_W-1:0]        in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcba_pkg::PIX_W-1:0]        out_value,
  output logic                              out_wrote
);
  // The block keeps an 8-bit paletted frame store (SCREEN_WIDTH x SCREEN_HEIGHT)
  // and a 64K-entry shade table, each in its own single-port RAM with a
  // registered read. Write transactions (pixel, shade entry) and pixel reads go
  // from acceptance to the finishing step; an off-screen point is dropped once
  // rounded and located; an on-screen antialias point takes one step to round
  // and locate, eight memory steps (five frame reads - four neighbors, borders
  // mirrored to the opposite side, then the center - overlapped with a chain of
  // five dependent shade lookups), and a finishing step that writes the blended
  // pixel back and hands it to the result register. The frame RAM port and the
  // dependent lookup chain through the shade RAM set the number of steps. One
  // transaction is in flight at a time; the result register lets the next
  // transaction be accepted while a result still waits for out_ready.
  // Entries read before they were written return whatever the RAM holds.
  import pcba_pkg::*;

  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int FRAME_AW   = $clog2(FRAME_SIZE);
  localparam int SHADE_AW   = $clog2(SHADE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // What the finishing cycle reports.
  localparam logic [1:0] RK_ZERO  = 2'd0;
  localparam logic [1:0] RK_PIX   = 2'd1;
  localparam logic [1:0] RK_SHADE = 2'd2;

  // Memory steps of an antialias point.
  localparam logic [2:0] STEP_RD_P0 = 3'd0;
  localparam logic [2:0] STEP_RD_P1 = 3'd1;
  localparam logic [2:0] STEP_RD_P2 = 3'd2;
  localparam logic [2:0] STEP_RD_P3 = 3'd3;
  localparam logic [2:0] STEP_RD_M  = 3'd4;
  localparam logic [2:0] STEP_CROSS = 3'd5;
  localparam logic [2:0] STEP_INNER = 3'd6;
  localparam logic [2:0] STEP_OUTER = 3'd7;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [1:0]          kind_r, kind_nxt;

  logic [PIX_W-1:0]    p0_r, p2_r, m_r, s1_r, cross_r;

  logic                out_valid_r;
  logic [PIX_W-1:0]    out_value_r;
  logic                out_wrote_r;

  logic                fr_we, fr_re;
  logic [FRAME_AW-1:0] fr_addr;
  logic [PIX_W-1:0]    fr_wdata, fr_rdata;
  logic                sh_we, sh_re;
  logic [SHADE_AW-1:0] sh_addr;
  logic [PIX_W-1:0]    sh_wdata, sh_rdata;

  pcba_pos_t           pos;
  logic [FRAME_AW-1:0] base_r;

  logic                accept;
  logic                fin_go;
  logic                addr_ok;
  logic [31:0]         addr_ext;
  logic [FRAME_AW-1:0] in_frame_addr;

  logic                interior;
  logic                edge_h;
  logic                edge_v;
  logic [FRAME_AW-1:0] l_addr, r_addr, t_addr, b_addr;
  logic [FRAME_AW-1:0] p1_addr, p2_addr, p3_addr;
  logic [PIX_W-1:0]    s2_sel;
  logic [PIX_W-1:0]    res_value;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // Finish only when the result register is free or being drained.
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_wrote = out_wrote_r;

  // Pixel ops ignore addresses past the frame.
  assign addr_ext      = 32'(in_address);
  assign addr_ok       = addr_ext < 32'(FRAME_SIZE);
  assign in_frame_addr = addr_ext[FRAME_AW-1:0];

  pcba_locate #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_locate (
    .clk    (clk),
    .load   (accept),
    .x_pos  (in_x_pos),
    .y_pos  (in_y_pos),
    .calc   (state_r == ST_PREP),
    .pos_r  (pos),
    .base_r (base_r)
  );

  // Neighbor addresses; at a border, mirror to the one neighbor that exists.
  assign l_addr = pos.at_left  ? base_r + FRAME_AW'(1) : base_r - FRAME_AW'(1);
  assign r_addr = pos.at_right ? base_r - FRAME_AW'(1) : base_r + FRAME_AW'(1);
  assign t_addr = pos.at_top   ? base_r + FRAME_AW'(SCREEN_WIDTH)
                               : base_r - FRAME_AW'(SCREEN_WIDTH);
  assign b_addr = pos.at_bot   ? base_r - FRAME_AW'(SCREEN_WIDTH)
                               : base_r + FRAME_AW'(SCREEN_WIDTH);

  assign edge_h   = pos.at_left || pos.at_right;
  assign edge_v   = pos.at_top  || pos.at_bot;
  assign interior = !edge_h && !edge_v;

  // Read order: interior pairs (l,t) and (b,r); border pairs (l,r) and (t,b).
  assign p1_addr = interior ? t_addr : r_addr;
  assign p2_addr = interior ? b_addr : t_addr;
  assign p3_addr = interior ? r_addr : b_addr;

  // On a top or bottom row the vertical sample is the mirrored pixel itself.
  assign s2_sel = edge_v ? p2_r : sh_rdata;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt = STEP_RD_P0;
          if (in_op == OP_AA_POINT) begin
            state_nxt = ST_PREP;
            kind_nxt  = RK_SHADE;
          end else begin
            state_nxt = ST_FIN;
            kind_nxt  = (in_op == OP_RD_PIX && addr_ok) ? RK_PIX : RK_ZERO;
          end
        end
      end
      ST_PREP: begin
        state_nxt = ST_RUN;
        step_nxt  = STEP_RD_P0;
      end
      ST_RUN: begin
        if (step_r == STEP_RD_P0 && !pos.onscreen) begin
          // Off-screen: drop the point, report zero.
          state_nxt = ST_FIN;
          kind_nxt  = RK_ZERO;
        end else if (step_r == STEP_OUTER) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory port steering.
  always_comb begin
    fr_we    = 1'b0;
    fr_re    = 1'b0;
    fr_addr  = base_r;
    fr_wdata = sh_rdata;
    sh_we    = 1'b0;
    sh_re    = 1'b0;
    sh_addr  = in_address;
    sh_wdata = in_data;
    if (accept) begin
      fr_addr  = in_frame_addr;
      fr_wdata = in_data;
      fr_we    = (in_op == OP_WR_PIX) && addr_ok;
      fr_re    = (in_op == OP_RD_PIX) && addr_ok;
      sh_we    = (in_op == OP_WR_SHADE);
    end else if (state_r == ST_RUN) begin
      case (step_r)
        STEP_RD_P0: begin
          fr_re   = pos.onscreen;
          fr_addr = l_addr;
        end
        STEP_RD_P1: begin
          fr_re   = 1'b1;
          fr_addr = p1_addr;
        end
        STEP_RD_P2: begin
          fr_re   = 1'b1;
          fr_addr = p2_addr;
          sh_re   = 1'b1;
          sh_addr = {p0_r, fr_rdata};
        end
        STEP_RD_P3: begin
          fr_re   = 1'b1;
          fr_addr = p3_addr;
        end
        STEP_RD_M: begin
          fr_re   = 1'b1;
          fr_addr = base_r;
          sh_re   = 1'b1;
          sh_addr = {p2_r, fr_rdata};
        end
        STEP_CROSS: begin
          sh_re   = 1'b1;
          sh_addr = {s1_r, s2_sel};
        end
        STEP_INNER: begin
          sh_re   = 1'b1;
          sh_addr = {m_r, sh_rdata};
        end
        STEP_OUTER: begin
          sh_re   = 1'b1;
          sh_addr = {cross_r, sh_rdata};
        end
        default: begin
          sh_re = 1'b0;
        end
      endcase
    end else if (fin_go && kind_r == RK_SHADE) begin
      // Write the blended pixel back over the center.
      fr_we    = 1'b1;
      fr_addr  = base_r;
      fr_wdata = sh_rdata;
    end
  end

  always_comb begin
    case (kind_r)
      RK_PIX:   res_value = fr_rdata;
      RK_SHADE: res_value = sh_rdata;
      default:  res_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_RD_P0;
      kind_r      <= RK_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      kind_r  <= kind_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold samples of the lookup chain; RAM read data stays put between reads.
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      case (step_r)
        STEP_RD_P1: p0_r <= fr_rdata;
        STEP_RD_P3: begin
          p2_r <= fr_rdata;
          s1_r <= edge_h ? p0_r : sh_rdata;
        end
        STEP_CROSS: m_r     <= fr_rdata;
        STEP_INNER: cross_r <= sh_rdata;
        default: begin
          cross_r <= cross_r;
        end
      endcase
    end
    if (fin_go) begin
      out_value_r <= res_value;
      out_wrote_r <= (kind_r == RK_SHADE);
    end
  end

  pcba_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_SIZE)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .re    (fr_re),
    .addr  (fr_addr),
    .wdata (fr_wdata),
    .rdata (fr_rdata)
  );

  pcba_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SHADE_DEPTH)
  ) u_shade_ram (
    .clk   (clk),
    .we    (sh_we),
    .re    (sh_re),
    .addr  (sh_addr),
    .wdata (sh_wdata),
    .rdata (sh_rdata)
  );

endmodule

FILE: hw/rtl/pcba_checker.sv
// Port-level checker of the point antialiaser and its bind to the top level.
module pcba_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [pcba_pkg::OP_W-1:0]         in_op,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pcba_pkg::PIX_W-1:0]        out_value,
  input logic                              out_wrote
);
  import pcba_pkg::*;

  logic [1:0]      cnt_r;
  logic [OP_W-1:0] op_r;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count transactions accepted but not yet answered; keep the last op.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      op_r  <= OP_WR_PIX;
    end else begin
      if (in_acc && !out_acc) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!in_acc && out_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
      if (in_acc) begin
        op_r <= in_op;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_wrote))
    else $error("result changed or dropped while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 2'd0 && cnt_r != 2'd3)
    else $error("result without a pending transaction");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("accepted a transaction while one is in flight");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cnt_r == 2'd1 && op_r != OP_AA_POINT
      |-> !out_wrote && (op_r == OP_RD_PIX || out_value == '0))
    else $error("non-point transaction reported a write or a value");

endmodule

bind point_cross_blend_antialias pcba_checker u_pcba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_op     (in_op),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_value (out_value),
  .out_wrote (out_wrote)
);

FILE: tb/testbench.sv
// Self-checking testbench of the point antialiaser: random transactions against a pixel predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcba_pkg::*;

  localparam int SCR_W        = DEF_SCREEN_WIDTH;
  localparam int SCR_H        = DEF_SCREEN_HEIGHT;
  localparam int FRAME_PIX    = SCR_W * SCR_H;
  localparam int N_TONES      = 16;
  localparam int TARGET_ITEMS = 1150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;

  // One input transaction, field by field as the ports carry it.
  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [ADDR_W-1:0]       address;
    logic [PIX_W-1:0]        data;
  } pcba_txn_t;

  // One result transaction.
  typedef struct {
    logic [PIX_W-1:0] value;
    logic             wrote;
  } pixel_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op = OP_WR_PIX;
  logic signed [POS_W-1:0] in_x_pos = '0;
  logic signed [POS_W-1:0] in_y_pos = '0;
  logic [ADDR_W-1:0]       in_address = '0;
  logic [PIX_W-1:0]        in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [PIX_W-1:0]        out_value;
  logic                    out_wrote;

  point_cross_blend_antialias dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_x_pos   (in_x_pos),
    .in_y_pos   (in_y_pos),
    .in_address (in_address),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_wrote  (out_wrote)
  );

  // 8 ns period: high half, then low half.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping.
  // Neither store may be read where it was never written. Keep every pixel
  // and every shade result inside a small set of tones, load the full
  // tone x tone corner of the shade table up front, and load each pixel
  // that a read or a point will touch before that transaction is queued.
  // ---------------------------------------------------------------------------
  pcba_txn_t        stim_q[$];
  bit               px_loaded [FRAME_PIX];
  int               loaded_px[$];
  bit [PIX_W-1:0]   tones [N_TONES];
  bit               is_tone [256];
  int               win_x [3] = '{0, 116, 232};
  int               win_y [3] = '{0, 76, 152};

  // ---------------------------------------------------------------------------
  // Predictor state: its own image of the frame store and the shade table.
  // ---------------------------------------------------------------------------
  bit [PIX_W-1:0]   frame_img [FRAME_PIX];
  bit [PIX_W-1:0]   shade_lut [SHADE_DEPTH];
  pixel_result_t    pixel_answers[$];

  // Run control shared by the driver, the receiver and the monitor.
  int               total_items = 1;
  int               n_sent;
  int               n_in;
  int               n_errors;
  int               hold_at = 1 << 30;
  int               pause_at = 1 << 30;
  int               hold_left;
  bit               hold_done;
  bit               pause_done;
  bit               in_fired;

  // Round a signed 9.8 coordinate to its pixel, flooring with an arithmetic shift.
  function automatic int pixel_coord(logic signed [POS_W-1:0] pos);
    int v;
    v = pos;
    return (v + int'(ROUND_BIAS)) >>> FRAC_W;
  endfunction

  function automatic bit [PIX_W-1:0] any_tone();
    return tones[$urandom_range(0, N_TONES - 1)];
  endfunction

  function automatic void queue_txn(logic [OP_W-1:0] op, int x_pos, int y_pos,
                                    int address, int data);
    pcba_txn_t t;
    t.op      = op;
    t.x_pos   = POS_W'(x_pos);
    t.y_pos   = POS_W'(y_pos);
    t.address = ADDR_W'(address);
    t.data    = PIX_W'(data);
    stim_q.push_back(t);
    if (op == OP_WR_PIX && address < FRAME_PIX && !px_loaded[address]) begin
      px_loaded[address] = 1'b1;
      loaded_px.push_back(address);
    end
  endfunction

  // In-frame pixels only ever hold tones; beyond the frame any byte goes.
  function automatic void queue_pixel_write(int address);
    queue_txn(OP_WR_PIX, $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
              address, address < FRAME_PIX ? int'(any_tone()) : int'($urandom_range(0, 255)));
  endfunction

  // Inside the tone corner the table must stay closed over the tones.
  function automatic void queue_shade_write(int address);
    bit [ADDR_W-1:0] a;
    a = ADDR_W'(address);
    queue_txn(OP_WR_SHADE, $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
              address, (is_tone[a[15:8]] && is_tone[a[7:0]]) ? int'(any_tone())
                                                             : int'($urandom_range(0, 255)));
  endfunction

  function automatic void load_px(int col, int row);
    if (col >= 0 && col < SCR_W && row >= 0 && row < SCR_H && !px_loaded[row * SCR_W + col])
      queue_pixel_write(row * SCR_W + col);
  endfunction

  function automatic void queue_read(int address);
    if (address < FRAME_PIX)
      load_px(address % SCR_W, address / SCR_W);
    queue_txn(OP_RD_PIX, $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
              address, $urandom_range(0, 255));
  endfunction

  // Load the centre and every neighbour that exists, then queue the point.
  function automatic void queue_point(int x_pos, int y_pos);
    int cx;
    int cy;
    cx = pixel_coord(POS_W'(x_pos));
    cy = pixel_coord(POS_W'(y_pos));
    if (cx >= 0 && cx < SCR_W && cy >= 0 && cy < SCR_H) begin
      load_px(cx, cy);
      load_px(cx - 1, cy);
      load_px(cx + 1, cy);
      load_px(cx, cy - 1);
      load_px(cx, cy + 1);
    end
    queue_txn(OP_AA_POINT, x_pos, y_pos, $urandom_range(0, 65535), $urandom_range(0, 255));
  endfunction

  // Pick a pixel in one of nine small windows: corners, edge middles, centre.
  function automatic void hot_pixel(output int cx, output int cy);
    cx = win_x[$urandom_range(0, 2)] + $urandom_range(0, 7);
    cy = win_y[$urandom_range(0, 2)] + $urandom_range(0, 7);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------
  function automatic bit [PIX_W-1:0] blend50(bit [PIX_W-1:0] a, bit [PIX_W-1:0] b);
    return shade_lut[{a, b}];
  endfunction

  function automatic bit [PIX_W-1:0] px_at(int col, int row);
    return frame_img[row * SCR_W + col];
  endfunction

  function automatic pixel_result_t antialias_predict(pcba_txn_t t);
    pixel_result_t  r;
    int             cx;
    int             cy;
    bit [PIX_W-1:0] horiz;
    bit [PIX_W-1:0] vert;
    bit [PIX_W-1:0] cross_px;
    r.value = '0;
    r.wrote = 1'b0;
    case (t.op)
      OP_WR_PIX: begin
        if (t.address < FRAME_PIX)
          frame_img[t.address] = t.data;
      end
      OP_WR_SHADE: begin
        shade_lut[t.address] = t.data;
      end
      OP_RD_PIX: begin
        if (t.address < FRAME_PIX)
          r.value = frame_img[t.address];
      end
      OP_AA_POINT: begin
        cx = pixel_coord(t.x_pos);
        cy = pixel_coord(t.y_pos);
        if (cx >= 0 && cx < SCR_W && cy >= 0 && cy < SCR_H) begin
          if (cx > 0 && cx < SCR_W - 1 && cy > 0 && cy < SCR_H - 1) begin
            // Interior: pair left with top and bottom with right.
            cross_px = blend50(blend50(px_at(cx - 1, cy), px_at(cx, cy - 1)),
                               blend50(px_at(cx, cy + 1), px_at(cx + 1, cy)));
          end else begin
            // Border: a missing neighbour is replaced by the opposite one.
            if (cx == 0)
              horiz = px_at(cx + 1, cy);
            else if (cx == SCR_W - 1)
              horiz = px_at(cx - 1, cy);
            else
              horiz = blend50(px_at(cx - 1, cy), px_at(cx + 1, cy));
            if (cy == 0)
              vert = px_at(cx, cy + 1);
            else if (cy == SCR_H - 1)
              vert = px_at(cx, cy - 1);
            else
              vert = blend50(px_at(cx, cy - 1), px_at(cx, cy + 1));
            cross_px = blend50(horiz, vert);
          end
          r.value = blend50(cross_px, blend50(px_at(cx, cy), cross_px));
          r.wrote = 1'b1;
          frame_img[cy * SCR_W + cx] = r.value;
        end
      end
    endcase
    return r;
  endfunction

  // Stall rates by phase: sender light and receiver heavy, then swapped, then none.
  function automatic int stall_pct(bit receiver);
    int phase;
    phase = (n_in * 3) / total_items;
    if (phase == 0)
      return receiver ? 58 : 12;
    else if (phase == 1)
      return receiver ? 12 : 58;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present transactions at the falling edge. Hold valid and payload
  // until the monitor has seen the handshake, then advance or idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pcba_txn_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      in_fired = 1'b0;
      // Pause once until every expected result has come back.
      if (n_sent == pause_at && !pause_done && pixel_answers.size() == 0)
        pause_done = 1'b1;
      if (stim_q.size() == 0 || (n_sent == pause_at && !pause_done) ||
          $urandom_range(0, 99) < stall_pct(1'b0)) begin
        in_valid <= 1'b0;
      end else begin
        t = stim_q.pop_front();
        in_op      <= t.op;
        in_x_pos   <= t.x_pos;
        in_y_pos   <= t.y_pos;
        in_address <= t.address;
        in_data    <= t.data;
        in_valid   <= 1'b1;
        n_sent++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off while the sender keeps
  // offering transactions, so the block backs up and drops in_ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && n_in >= hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct(1'b1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, predict every accepted input transaction and
  // check every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pcba_txn_t     t;
    pixel_result_t exp_r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        t.op      = in_op;
        t.x_pos   = in_x_pos;
        t.y_pos   = in_y_pos;
        t.address = in_address;
        t.data    = in_data;
        pixel_answers.push_back(antialias_predict(t));
        in_fired = 1'b1;
        n_in++;
      end
      if (out_valid && out_ready) begin
        if (pixel_answers.size() == 0) begin
          $error("unexpected result transaction: value %0d wrote %0d", out_value, out_wrote);
          n_errors++;
        end else begin
          exp_r = pixel_answers.pop_front();
          if (out_value !== exp_r.value) begin
            $error("value mismatch: expected %0d, actual %0d", exp_r.value, out_value);
            n_errors++;
          end
          if (out_wrote !== exp_r.wrote) begin
            $error("wrote mismatch: expected %0d, actual %0d", exp_r.wrote, out_wrote);
            n_errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Build the stimulus, run reset, wait for the drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    int sel;
    int cx;
    int cy;
    int addr;

    // Tone set: all-zeros and all-ones so every data bit takes both values.
    tones[0] = 8'h00;
    tones[1] = 8'hFF;
    for (int i = 2; i < N_TONES; i++)
      tones[i] = $urandom_range(0, 255);
    for (int i = 0; i < N_TONES; i++)
      is_tone[tones[i]] = 1'b1;

    // Load the tone corner of the shade table.
    for (int i = 0; i < N_TONES; i++)
      for (int j = 0; j < N_TONES; j++)
        queue_txn(OP_WR_SHADE, 0, 0, {tones[i], tones[j]}, any_tone());

    // Directed: frame ends, writes and reads beyond the frame, field extremes.
    queue_pixel_write(0);
    queue_pixel_write(FRAME_PIX - 1);
    queue_txn(OP_WR_PIX, -65536, 65535, FRAME_PIX, 8'hA5);
    queue_txn(OP_WR_PIX, 65535, -65536, 16'hFFFF, 8'h5A);
    queue_read(0);
    queue_read(FRAME_PIX - 1);
    queue_read(FRAME_PIX);
    queue_read(16'hFFFF);
    // Points far off screen on either side.
    queue_point(-65536, 0);
    queue_point(65535, 65535);
    queue_point(0, -65536);
    // Rounding at the left edge: -128 falls off, -127 lands on column 0.
    queue_point(-128, 80 * 256);
    queue_point(-127, 80 * 256);
    // Rounding at the right, bottom and top edges.
    queue_point(239 * 256 + 128, 159 * 256 + 128);
    queue_point(239 * 256 + 129, 10 * 256);
    queue_point(50 * 256, 159 * 256 + 129);
    queue_point(50 * 256, -127);
    // Remaining corners, edge middles and two adjacent interior points.
    queue_point(0, 0);
    queue_point(239 * 256, 0);
    queue_point(0, 159 * 256);
    queue_point(120 * 256, 0);
    queue_point(239 * 256, 80 * 256);
    queue_point(120 * 256, 159 * 256);
    queue_point(120 * 256 - 128, 80 * 256 + 128);
    queue_point(120 * 256 + 5, 80 * 256 - 3);

    // Random: half points, most of them in small windows so they chain on earlier results.
    while (stim_q.size() < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        hot_pixel(cx, cy);
        queue_point(cx * 256 + $urandom_range(0, 255) - 127,
                    cy * 256 + $urandom_range(0, 255) - 127);
      end else if (sel < 50) begin
        queue_point($urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536);
      end else if (sel < 68) begin
        if ($urandom_range(0, 9) < 7) begin
          hot_pixel(cx, cy);
          queue_pixel_write(cy * SCR_W + cx);
        end else begin
          queue_pixel_write($urandom_range(0, 65535));
        end
      end else if (sel < 84) begin
        if ($urandom_range(0, 1) == 0 && loaded_px.size() != 0)
          addr = loaded_px[$urandom_range(0, loaded_px.size() - 1)];
        else
          addr = $urandom_range(0, 65535);
        queue_read(addr);
      end else begin
        queue_shade_write($urandom_range(0, 65535));
      end
    end

    total_items = stim_q.size();
    hold_at     = total_items / 6;
    pause_at    = total_items / 2;

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and accepted, every prediction matched.
    while (stim_q.size() != 0 || in_valid || pixel_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && pixel_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: give up far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
